// File: sv/rdrc_pkg.sv
package rdrc_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int HANDLE_BITS_DEF = 8;

  localparam int ID_W    = 32;
  localparam int RADDR_W = 48;
  localparam int LEN_W   = 16;
  localparam int SIZE_W  = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_SIZE   = 1'b1;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    xid;
    logic [ID_W-1:0]    proc_num;
    logic [ID_W-1:0]    vers_num;
    logic [ID_W-1:0]    prog_num;
    logic [RADDR_W-1:0] remote_addr;
  } key_t;

  typedef struct packed {
    logic              enable;
    logic [SIZE_W-1:0] size;
  } cfg_t;

endpackage

// File: sv/rdrc_if.sv
interface rdrc_req_if #(parameter int HANDLE_BITS = 8) ();
  import rdrc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [ID_W-1:0]        xid;
  logic [ID_W-1:0]        proc_num;
  logic [ID_W-1:0]        vers_num;
  logic [ID_W-1:0]        prog_num;
  logic [RADDR_W-1:0]     remote_addr;
  logic [HANDLE_BITS-1:0] reply_handle_in;
  logic [LEN_W-1:0]       reply_len_in;

  modport source (
    output valid, action, xid, proc_num, vers_num, prog_num, remote_addr,
           reply_handle_in, reply_len_in,
    input  ready
  );
  modport sink (
    input  valid, action, xid, proc_num, vers_num, prog_num, remote_addr,
           reply_handle_in, reply_len_in,
    output ready
  );
endinterface

interface rdrc_rsp_if #(parameter int HANDLE_BITS = 8) ();
  import rdrc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [HANDLE_BITS-1:0] reply_handle;
  logic [LEN_W-1:0]       reply_len;
  logic                   evicted_valid;
  logic [HANDLE_BITS-1:0] evicted_handle;

  modport source (
    output valid, hit, reply_handle, reply_len, evicted_valid, evicted_handle,
    input  ready
  );
  modport sink (
    input  valid, hit, reply_handle, reply_len, evicted_valid, evicted_handle,
    output ready
  );
endinterface

// File: sv/rdrc_cfg.sv
module rdrc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdrc_pkg::PADDR_W-1:0]  paddr,
  input  logic [rdrc_pkg::PDATA_W-1:0]  pwdata,
  output logic [rdrc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output rdrc_pkg::cfg_t                cfg
);
  import rdrc_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.size   <= SIZE_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_ENABLE: cfg.enable <= pwdata[0];
        REG_SIZE:   cfg.size   <= pwdata[SIZE_W-1:0];
        default:    cfg.enable <= cfg.enable;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, cfg.enable};
      REG_SIZE:   prdata = {{(PDATA_W-SIZE_W){1'b0}}, cfg.size};
      default:    prdata = '0;
    endcase
  end

endmodule

// File: sv/rdrc_ram.sv
module rdrc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rdrc_ctrl.sv
module rdrc_ctrl #(
  parameter int DEPTH       = rdrc_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = rdrc_pkg::HANDLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rdrc_pkg::cfg_t cfg,
  rdrc_req_if.sink       req,
  rdrc_rsp_if.source     rsp
);
  import rdrc_pkg::*;

  localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KEY_W  = $bits(key_t);
  localparam int WORD_W = KEY_W + HANDLE_BITS + LEN_W + IW;
  localparam logic [IW-1:0] MAX_AGE  = IW'(DEPTH - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t                 state;
  logic [IW:0]            rd_cnt;
  logic                   cmp_vld;
  logic [IW-1:0]          cmp_idx;
  logic [DEPTH-1:0]       valid;
  logic                   live;
  logic                   action;
  key_t                   key;
  key_t                   skey;
  logic [HANDLE_BITS-1:0] hin;
  logic [LEN_W-1:0]       lin;
  logic [IW-1:0]          slot;
  logic [IW-1:0]          next_victim;
  logic                   found;
  logic [IW-1:0]          best_age;
  logic [HANDLE_BITS-1:0] best_handle;
  logic [LEN_W-1:0]       best_len;
  logic                   ev_valid;
  logic [HANDLE_BITS-1:0] ev_handle;
  logic                   out_valid;
  logic                   out_hit;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [LEN_W-1:0]       out_len;
  logic                   out_ev_valid;
  logic [HANDLE_BITS-1:0] out_ev_handle;

  logic [IW:0]            eff;
  logic [IW-1:0]          slot_in;
  logic [IW:0]            slot_inc;
  logic [IW-1:0]          nv;
  logic                   out_free;
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [WORD_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [IW-1:0]          mem_raddr;
  logic [WORD_W-1:0]      mem_rdata;
  key_t                   w_key;
  logic [HANDLE_BITS-1:0] w_handle;
  logic [LEN_W-1:0]       w_len;
  logic [IW-1:0]          w_age;
  logic                   w_valid;
  logic                   match;

  rdrc_ram #(.DEPTH(DEPTH), .WIDTH(WORD_W), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // size clamped to 1..DEPTH
  always_comb begin
    if (cfg.size == '0) begin
      eff = (IW+1)'(1);
    end else if (32'(cfg.size) > DEPTH) begin
      eff = (IW+1)'(DEPTH);
    end else begin
      eff = (IW+1)'(cfg.size);
    end
  end

  assign slot_in  = ({1'b0, next_victim} >= eff) ? '0 : next_victim;
  assign slot_inc = {1'b0, slot} + (IW+1)'(1);
  assign nv       = (slot_inc >= eff) ? '0 : slot_inc[IW-1:0];
  assign out_free = !out_valid || rsp.ready;

  assign w_key    = mem_rdata[WORD_W-1 -: KEY_W];
  assign w_handle = mem_rdata[HANDLE_BITS+LEN_W+IW-1 -: HANDLE_BITS];
  assign w_len    = mem_rdata[LEN_W+IW-1 -: LEN_W];
  assign w_age    = mem_rdata[IW-1:0];
  assign w_valid  = valid[cmp_idx];
  assign match    = w_valid && (w_key == key);

  assign mem_re    = (state == SCAN) && (rd_cnt < (IW+1)'(DEPTH));
  assign mem_raddr = rd_cnt[IW-1:0];

  // single write port: age update during the scan, new entry at the end
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmp_idx;
    mem_wdata = {w_key, w_handle, w_len, w_age + IW'(1)};
    if (state == SCAN && cmp_vld && action == ACT_INSERT && cmp_idx != slot &&
        w_valid && w_age != MAX_AGE) begin
      mem_we = 1'b1;
    end else if (state == DONE && out_free && live && action == ACT_INSERT) begin
      mem_we    = 1'b1;
      mem_waddr = slot;
      mem_wdata = {skey, hin, lin, {IW{1'b0}}};
    end
  end

  assign req.ready          = (state == IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.hit            = out_hit;
  assign rsp.reply_handle   = out_handle;
  assign rsp.reply_len      = out_len;
  assign rsp.evicted_valid  = out_ev_valid;
  assign rsp.evicted_handle = out_ev_handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      valid       <= '0;
      next_victim <= '0;
      skey        <= '0;
      out_valid   <= 1'b0;
      cmp_vld     <= 1'b0;
      rd_cnt      <= '0;
    end else begin
      if (rsp.ready && state != DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req.valid) begin
            live        <= cfg.enable;
            action      <= req.action;
            key         <= '{req.xid, req.proc_num, req.vers_num, req.prog_num,
                             req.remote_addr};
            hin         <= req.reply_handle_in;
            lin         <= req.reply_len_in;
            slot        <= slot_in;
            found       <= 1'b0;
            best_age    <= '0;
            best_handle <= '0;
            best_len    <= '0;
            ev_valid    <= 1'b0;
            ev_handle   <= '0;
            rd_cnt      <= '0;
            cmp_vld     <= 1'b0;
            state       <= cfg.enable ? SCAN : DONE;
          end
        end
        SCAN: begin
          if (mem_re) begin
            rd_cnt <= rd_cnt + (IW+1)'(1);
          end
          cmp_vld <= mem_re;
          cmp_idx <= mem_raddr;
          if (cmp_vld) begin
            if (action == ACT_LOOKUP) begin
              if (match && (!found || w_age < best_age)) begin
                best_age    <= w_age;
                best_handle <= w_handle;
                best_len    <= w_len;
              end
              if (match) begin
                found <= 1'b1;
              end
            end else if (cmp_idx == slot && w_valid) begin
              ev_valid  <= 1'b1;
              ev_handle <= w_handle;
            end
            if (cmp_idx == LAST_IDX) begin
              state <= DONE;
            end
          end
        end
        DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_hit       <= found;
            out_handle    <= best_handle;
            out_len       <= best_len;
            out_ev_valid  <= ev_valid;
            out_ev_handle <= ev_handle;
            if (live && action == ACT_LOOKUP && !found) begin
              skey <= key;
            end
            if (live && action == ACT_INSERT) begin
              valid[slot] <= 1'b1;
              next_victim <= nv;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_valid_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(valid) >= $past($countones(valid)))
    else $error("entry valid bit lost");

  a_one_fill: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(valid) <= $past($countones(valid)) + 1)
    else $error("more than one entry filled at once");

  a_hit_or_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_ev_valid))
    else $error("hit and eviction in one word");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == DONE)
    else $error("result loaded outside completion");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == SCAN |-> rd_cnt <= (IW+1)'(DEPTH))
    else $error("scan counter overrun");

endmodule

// File: sv/rpc_duplicate_request_cache_unit.sv
// lookup or insert: the word scans every entry, then the result is registered from DONE
// cache disabled: the word skips the scan and goes to DONE, table untouched
// enabled words scan the 1R1W entry memory one entry per cycle, so DEPTH sets the rate
// reset clears valid bits, victim pointer and saved key; enable 0, size 64
// entry memory contents are not cleared by reset
module rpc_duplicate_request_cache_unit #(
  parameter int DEPTH       = rdrc_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = rdrc_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  rdrc_req_if.sink                      req,
  rdrc_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdrc_pkg::PADDR_W-1:0]  paddr,
  input  logic [rdrc_pkg::PDATA_W-1:0]  pwdata,
  output logic [rdrc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import rdrc_pkg::*;

  cfg_t cfg;

  rdrc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rdrc_ctrl #(.DEPTH(DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

endmodule

// File: dv/rdrc_cache_monitor.sv
module rdrc_cache_monitor #(
  parameter int DEPTH       = rdrc_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = rdrc_pkg::HANDLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  rdrc_req_if                          req,
  rdrc_rsp_if                          rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rdrc_pkg::PADDR_W-1:0] paddr,
  input  logic [rdrc_pkg::PDATA_W-1:0] pwdata,
  input  logic                         pready,
  output int                           failures,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rdrc_pkg::*;

  typedef struct packed {
    logic                   hit;
    logic [HANDLE_BITS-1:0] reply_handle;
    logic [LEN_W-1:0]       reply_len;
    logic                   evicted_valid;
    logic [HANDLE_BITS-1:0] evicted_handle;
  } reply_t;

  logic                   slot_valid  [DEPTH];
  key_t                   slot_key    [DEPTH];
  logic [HANDLE_BITS-1:0] slot_handle [DEPTH];
  logic [LEN_W-1:0]       slot_len    [DEPTH];
  int                     slot_age    [DEPTH];
  int                     victim;
  key_t                   missed_key;
  logic                   cache_on;
  logic [SIZE_W-1:0]      cache_size;
  reply_t                 replies_due [$];

  function automatic reply_t apply_word(input logic action, input key_t k,
                                        input logic [HANDLE_BITS-1:0] h,
                                        input logic [LEN_W-1:0] l);
    reply_t r;
    int     best;
    bit     found;
    int     used;
    int     slot;
    r     = '0;
    best  = 0;
    found = 1'b0;
    if (!cache_on) return r;
    if (action == ACT_LOOKUP) begin
      // newest match wins, lowest slot on equal age
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_valid[i] && slot_key[i] == k) begin
          if (!found || slot_age[i] < slot_age[best]) best = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.hit          = 1'b1;
        r.reply_handle = slot_handle[best];
        r.reply_len    = slot_len[best];
      end else begin
        missed_key = k;
      end
      return r;
    end
    used = (cache_size == 0) ? 1 : (int'(cache_size) > DEPTH) ? DEPTH : int'(cache_size);
    slot = (victim >= used) ? 0 : victim;
    if (slot_valid[slot]) begin
      r.evicted_valid  = 1'b1;
      r.evicted_handle = slot_handle[slot];
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (i != slot && slot_valid[i] && slot_age[i] < DEPTH - 1) slot_age[i]++;
    end
    slot_valid[slot]  = 1'b1;
    slot_key[slot]    = missed_key;
    slot_handle[slot] = h;
    slot_len[slot]    = l;
    slot_age[slot]    = 0;
    victim = (slot + 1 >= used) ? 0 : slot + 1;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= 10)
        $display("@%0t %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    key_t   k;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) slot_valid[i] = 1'b0;
      victim     = 0;
      missed_key = '0;
      cache_on   = 1'b0;
      cache_size = SIZE_RESET;
      replies_due.delete();
      failures   = 0;
      pending    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ENABLE) cache_on = pwdata[0];
        else cache_size = pwdata[SIZE_W-1:0];
      end
      if (req.valid && req.ready) begin
        k = {req.xid, req.proc_num, req.vers_num, req.prog_num, req.remote_addr};
        replies_due.push_back(apply_word(req.action, k, req.reply_handle_in,
                                         req.reply_len_in));
      end
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          failures++;
          if (failures <= 10) $display("@%0t result word with none outstanding", $realtime);
        end else begin
          want = replies_due.pop_front();
          check_field("hit", 32'(want.hit), 32'(rsp.hit));
          check_field("reply_handle", 32'(want.reply_handle), 32'(rsp.reply_handle));
          check_field("reply_len", 32'(want.reply_len), 32'(rsp.reply_len));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(rsp.evicted_valid));
          check_field("evicted_handle", 32'(want.evicted_handle), 32'(rsp.evicted_handle));
        end
      end
      pending = replies_due.size();
    end
  end

endmodule

// File: dv/rpc_duplicate_request_cache_unit_tb.sv
module rpc_duplicate_request_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdrc_pkg::*;

  localparam int DEPTH           = DEPTH_DEF;
  localparam int HB              = HANDLE_BITS_DEF;
  localparam int POOL            = 16;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 9;

  typedef struct packed {
    logic             action;
    key_t             key;
    logic [HB-1:0]    handle;
    logic [LEN_W-1:0] len;
  } word_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 failures;
  int                 pending;
  int                 src_idle_pct  = 35;
  int                 sink_idle_pct = 81;
  logic               pressure_go   = 1'b0;
  key_t               key_pool [POOL];
  int                 phase_size [PHASES] = '{64, 0, 5, 127, 1, 33, 3, 64, 17};
  logic               phase_on   [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                              1'b0, 1'b1};

  rdrc_req_if #(.HANDLE_BITS(HB)) req_ch ();
  rdrc_rsp_if #(.HANDLE_BITS(HB)) rsp_ch ();

  rpc_duplicate_request_cache_unit #(.DEPTH(DEPTH), .HANDLE_BITS(HB)) dut (
    .clk, .rst, .req(req_ch), .rsp(rsp_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rdrc_cache_monitor #(.DEPTH(DEPTH), .HANDLE_BITS(HB)) monitor (
    .clk, .rst, .req(req_ch), .rsp(rsp_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .failures, .pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic key_t fresh_key();
    key_t k;
    k.xid         = $urandom;
    k.proc_num    = $urandom;
    k.vers_num    = $urandom;
    k.prog_num    = $urandom;
    k.remote_addr = RADDR_W'({$urandom, $urandom});
    return k;
  endfunction

  // near miss: one bit of one key field inverted
  function automatic key_t flip_bit(input key_t k, input int field);
    int b;
    b = $urandom_range(ID_W - 1);
    case (field)
      0: k.xid[b]      = ~k.xid[b];
      1: k.proc_num[b] = ~k.proc_num[b];
      2: k.vers_num[b] = ~k.vers_num[b];
      3: k.prog_num[b] = ~k.prog_num[b];
      default: begin
        b = $urandom_range(RADDR_W - 1);
        k.remote_addr[b] = ~k.remote_addr[b];
      end
    endcase
    return k;
  endfunction

  function automatic word_t make_lookup(input key_t k);
    word_t w;
    w.action = ACT_LOOKUP;
    w.key    = k;
    w.handle = HB'($urandom);
    w.len    = LEN_W'($urandom);
    return w;
  endfunction

  function automatic word_t make_insert(input logic [HB-1:0] h, input logic [LEN_W-1:0] l);
    word_t w;
    w.action = ACT_INSERT;
    w.key    = fresh_key();
    w.handle = h;
    w.len    = l;
    return w;
  endfunction

  task automatic send_word(input word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.action          <= w.action;
    req_ch.xid             <= w.key.xid;
    req_ch.proc_num        <= w.key.proc_num;
    req_ch.vers_num        <= w.key.vers_num;
    req_ch.prog_num        <= w.key.prog_num;
    req_ch.remote_addr     <= w.key.remote_addr;
    req_ch.reply_handle_in <= w.handle;
    req_ch.reply_len_in    <= w.len;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random_insert();
    send_word(make_insert(HB'($urandom), LEN_W'($urandom)));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  // back-to-back writes of both registers
  task automatic configure(input logic en, input int size);
    for (int r = 0; r < 2; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {(r == 0) ? REG_ENABLE : REG_SIZE, 2'b00};
      pwdata  <= (r == 0) ? PDATA_W'(en) : PDATA_W'(size);
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      @(negedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_traffic(input int n);
    key_t k;
    int   r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if ($urandom_range(19) == 0) key_pool[$urandom_range(POOL - 1)] = fresh_key();
      k = key_pool[$urandom_range(POOL - 1)];
      if (r < 10) k = flip_bit(k, $urandom_range(4));
      else if (r < 15) k = fresh_key();
      if (r < 70) begin
        send_word(make_lookup(k));
        if ($urandom_range(3) != 0) send_random_insert();
      end else if (r < 88) begin
        send_word(make_lookup(k));
      end else begin
        send_random_insert();
      end
    end
  endtask

  // result side
  initial begin
    int hold;
    bit held;
    hold         = 0;
    held         = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_go && !held) begin
        hold = HOLD_OFF_CYCLES;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    key_t k_max;
    key_t k_zero;
    key_t near_key;
    key_t twin_key;
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    req_ch.valid           = 1'b0;
    req_ch.action          = ACT_LOOKUP;
    req_ch.xid             = '0;
    req_ch.proc_num        = '0;
    req_ch.vers_num        = '0;
    req_ch.prog_num        = '0;
    req_ch.remote_addr     = '0;
    req_ch.reply_handle_in = '0;
    req_ch.reply_len_in    = '0;
    k_max  = '1;
    k_zero = '0;
    for (int i = 0; i < POOL; i++) key_pool[i] = fresh_key();
    key_pool[0] = k_max;
    key_pool[1] = k_zero;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // disabled out of reset
    send_word(make_lookup(k_max));
    send_word(make_insert(8'h5A, 16'h1234));
    wait_drained();
    configure(1'b1, DEPTH);

    // insert before any miss uses the all-zero key
    send_word(make_insert(8'h11, 16'h0001));
    send_word(make_lookup(k_zero));
    send_word(make_lookup(k_max));
    send_word(make_insert('1, '1));
    send_word(make_lookup(k_max));
    // insert after a hit reuses the last missed key
    send_word(make_insert(8'h22, 16'h0002));
    send_word(make_lookup(k_max));
    for (int f = 0; f < 4; f++) send_word(make_lookup(flip_bit(k_max, f)));
    near_key = flip_bit(k_max, 4);
    send_word(make_lookup(near_key));
    send_word(make_insert('0, '0));
    send_word(make_lookup(near_key));

    // entries survive a disable
    wait_drained();
    configure(1'b0, DEPTH);
    send_word(make_lookup(k_max));
    send_word(make_insert(8'h33, 16'h0003));
    wait_drained();
    configure(1'b1, DEPTH);
    send_word(make_lookup(k_max));

    // size lowered under the victim pointer, slots beyond still hit
    wait_drained();
    configure(1'b1, 2);
    repeat (3) send_random_insert();
    send_word(make_lookup(near_key));

    // two copies of one key age out to equal age
    wait_drained();
    configure(1'b1, DEPTH);
    twin_key = fresh_key();
    send_word(make_lookup(twin_key));
    send_word(make_insert(8'hA1, 16'h00A1));
    send_word(make_insert(8'hA2, 16'h00A2));
    wait_drained();
    configure(1'b1, 1);
    send_word(make_lookup(fresh_key()));
    repeat (DEPTH) send_random_insert();
    send_word(make_lookup(twin_key));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      configure(phase_on[ph], phase_size[ph]);
      if (ph < 3) begin
        src_idle_pct  <= 35;
        sink_idle_pct <= 81;
      end else if (ph < 6) begin
        src_idle_pct  <= 81;
        sink_idle_pct <= 35;
      end else begin
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
      end
      if (ph == 6) pressure_go <= 1'b1;
      run_traffic(phase_on[ph] ? 92 : 30);
    end

    wait_drained();
    repeat (DEPTH + 8) @(negedge clk);
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
